// ===== sv/bsf_pkg.sv =====
// bsf_pkg: word types, codes and lane interface types of the barostat scale factor unit
// depends on nothing; used by every module of the block
package bsf_pkg;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } out_word_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_CLAMPED     = 2'd2;
  localparam logic [1:0] ST_SATURATED   = 2'd3;

  localparam logic [2:0] MODE_OFF  = 3'd0;
  localparam logic [2:0] MODE_ISO  = 3'd1;
  localparam logic [2:0] MODE_ANI  = 3'd2;
  localparam logic [2:0] MODE_SEMI = 3'd3;
  localparam logic [2:0] MODE_FULL = 3'd4;

  localparam logic [3:0] CFG_MODE    = 4'd0;
  localparam logic [3:0] CFG_GAIN    = 4'd1;
  localparam logic [3:0] CFG_TGT_X   = 4'd2;
  localparam logic [3:0] CFG_TGT_Y   = 4'd3;
  localparam logic [3:0] CFG_TGT_Z   = 4'd4;
  localparam logic [3:0] CFG_GROUP_X = 4'd5;
  localparam logic [3:0] CFG_GROUP_Y = 4'd6;
  localparam logic [3:0] CFG_GROUP_Z = 4'd7;

  localparam logic [31:0] FACTOR_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic               start;
    logic               fixed;
    logic signed [35:0] dsum;
    logic [1:0]         k;
  } lane_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [1:0]  st;
    logic [31:0] factor;
  } lane_sts_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL0, L_MUL1, L_PREP, L_TRY, L_CMP
  } lane_state_e;

  function automatic logic [1:0] stat_max(input logic [1:0] a, input logic [1:0] b);
    stat_max = (a > b) ? a : b;
  endfunction

endpackage

// ===== sv/bsf_root_lane.sv =====
// bsf_root_lane: one factor lane, gain product in L_MUL0 and L_MUL1 then a bit-serial cube root
// depends on bsf_pkg
module bsf_root_lane import bsf_pkg::*; #(
  parameter int FACTOR_FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lane_cmd_t   cmd_i,
  input  logic [47:0] gain_i,
  output lane_sts_t   sts_o
);

  localparam int SHL  = 3 * FACTOR_FRAC_BITS - 64;
  localparam int SHLP = (SHL > 0) ? SHL : 0;
  localparam int SHRN = (SHL < 0) ? -SHL : 0;
  localparam int LIM  = 96 - SHLP;
  localparam int LIMC = (LIM > 0) ? LIM : 0;
  localparam logic [31:0] ONE_F =
    (FACTOR_FRAC_BITS >= 31) ? FACTOR_MAX : 32'(64'd1 << FACTOR_FRAC_BITS);

  lane_state_e state_q, state_d;

  logic         neg_q;
  logic [35:0]  mag_q;
  logic [1:0]   k_q;
  logic [83:0]  acc_q;
  logic [96:0]  x_q;
  logic [30:0]  r_q, c_q;
  logic [63:0]  r2_q, c2_q;
  logic [99:0]  r3_q, c3_q;
  logic [4:0]   b_q;
  logic [31:0]  factor_q;
  logic [1:0]   st_q;

  // prep stage
  logic [84:0]  base, n;
  logic         clamp, ovf, big;
  logic [207:0] xs;
  logic [96:0]  x_d;
  logic [96:0]  kt;

  always_comb begin
    base  = {17'd0, k_q, 66'd0} >> 2;
    base  = 85'({k_q, 64'd0});
    clamp = !neg_q && (base <= {1'b0, acc_q});
    n     = neg_q ? (base + {1'b0, acc_q}) : (base - {1'b0, acc_q});
    ovf   = (LIM <= 0) || ((n >> LIMC) != '0);
    xs    = {123'd0, n} << SHLP;
    x_d   = (SHL >= 0) ? xs[96:0] : 97'(n >> SHRN);
    kt    = {2'b00, k_q, 93'd0};
    big   = (x_d >= kt);
  end

  // one root digit: candidate square and cube from running values
  logic [30:0] c_d;
  logic [63:0] c2_d;
  logic [99:0] c3_d, t2, t1, kc3;
  logic        take;

  always_comb begin
    c_d  = r_q | (31'd1 << b_q);
    c2_d = r2_q + ({33'd0, r_q} << (b_q + 5'd1)) + (64'd1 << {b_q, 1'b0});
    t2   = {36'd0, r2_q} << b_q;
    t1   = {69'd0, r_q} << {b_q, 1'b0};
    c3_d = r3_q + t2 + (t2 << 1) + t1 + (t1 << 1) + (100'd1 << (7'(b_q) * 7'd3));
    case (k_q)
      2'd3:    kc3 = c3_q + (c3_q << 1);
      2'd2:    kc3 = c3_q << 1;
      default: kc3 = c3_q;
    endcase
    take = (kc3 <= {3'd0, x_q});
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE: if (cmd_i.start && !cmd_i.fixed) state_d = L_MUL0;
      L_MUL0: state_d = L_MUL1;
      L_MUL1: state_d = L_PREP;
      L_PREP: state_d = (clamp || ovf || big) ? L_IDLE : L_TRY;
      L_TRY:  state_d = L_CMP;
      L_CMP:  state_d = (b_q == 5'd0) ? L_IDLE : L_TRY;
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    sts_o.busy   = (state_q != L_IDLE);
    sts_o.st     = st_q;
    sts_o.factor = factor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          neg_q    <= cmd_i.dsum[35];
          mag_q    <= cmd_i.dsum[35] ? 36'(-cmd_i.dsum) : 36'(cmd_i.dsum);
          k_q      <= cmd_i.k;
          st_q     <= ST_OK;
          factor_q <= ONE_F;
        end
      end
      L_MUL0: acc_q <= 84'(gain_i * mag_q[17:0]);
      L_MUL1: acc_q <= acc_q + (84'(gain_i * mag_q[35:18]) << 18);
      L_PREP: begin
        x_q  <= x_d;
        r_q  <= '0;
        r2_q <= '0;
        r3_q <= '0;
        b_q  <= 5'd30;
        if (clamp) begin
          factor_q <= '0;
          st_q     <= ST_CLAMPED;
        end else if (ovf || big) begin
          factor_q <= FACTOR_MAX;
          st_q     <= ST_SATURATED;
        end
      end
      L_TRY: begin
        c_q  <= c_d;
        c2_q <= c2_d;
        c3_q <= c3_d;
      end
      L_CMP: begin
        if (take) begin
          r_q  <= c_q;
          r2_q <= c2_q;
          r3_q <= c3_q;
        end
        if (b_q == 5'd0) factor_q <= {1'b0, take ? c_q : r_q};
        else b_q <= b_q - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/bsf_scale_lane.sv =====
// bsf_scale_lane: one axis of the scale path, registered product then floor shift and clamp
// depends on bsf_pkg
module bsf_scale_lane import bsf_pkg::*; #(
  parameter int COORD_WIDTH      = 32,
  parameter int FACTOR_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [31:0] vec_i,
  input  logic [31:0]        factor_i,
  output logic [31:0]        coord_o,
  output logic               sat_o
);

  localparam logic signed [63:0] QHI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] QLO = -QHI - 64'sd1;

  logic signed [63:0] p_q, q;

  always_ff @(posedge clk_i) begin
    if (load_i) p_q <= 64'(vec_i * $signed({1'b0, factor_i}));
  end

  always_comb begin
    q     = p_q >>> FACTOR_FRAC_BITS;
    sat_o = (q > QHI) || (q < QLO);
    if (q > QHI)      coord_o = QHI[31:0];
    else if (q < QLO) coord_o = QLO[31:0];
    else              coord_o = q[31:0];
  end

endmodule

// ===== sv/barostat_scale_factor_unit.sv =====
// barostat scale factor unit: scale words pass a product and an output register, one word
// per cycle unless the output stalls or lanes run. update words in isotropic, anisotropic
// and semi-anisotropic modes run their root lanes in parallel: product, prep, a try and a
// compare step per root bit over 31 bits, then merge; clamped or saturated lanes finish
// after prep. other update words go straight to the output. reset: config 0, factors 1.0.
module barostat_scale_factor_unit import bsf_pkg::*; #(
  parameter int COORD_WIDTH      = 32,
  parameter int FACTOR_FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [47:0] cfg_wdata_i
);

  localparam logic [31:0] ONE_F =
    (FACTOR_FRAC_BITS >= 31) ? FACTOR_MAX : 32'(64'd1 << FACTOR_FRAC_BITS);

  logic [2:0]         mode_q;
  logic [47:0]        gain_q;
  logic signed [31:0] tgt_q [3];
  logic [1:0]         grp_q [3];
  logic [31:0]        fac_q [3];
  logic               busy_q, s1_v_q, out_v_q;
  out_word_t          out_q;

  logic signed [31:0] vec [3];
  logic        is_scale, ready, in_acc, out_load, lane_mode, upd_imm, lane_done;
  lane_cmd_t   cmd [3];
  lane_sts_t   sts [3];
  logic [31:0] coord [3];
  logic        sat [3];
  logic [1:0]  merge_st;

  assign vec[0] = in_word_i.vec_x;
  assign vec[1] = in_word_i.vec_y;
  assign vec[2] = in_word_i.vec_z;

  assign is_scale  = in_word_i.operation;
  assign out_load  = !out_v_q || !out_stall_i;
  assign ready     = !busy_q && (is_scale ? (!s1_v_q || out_load) : (!s1_v_q && !out_v_q));
  assign in_stall_o = !ready;
  assign in_acc    = in_valid_i && ready;
  assign lane_mode = mode_q inside {MODE_ISO, MODE_ANI, MODE_SEMI};
  assign upd_imm   = in_acc && !is_scale && !lane_mode;
  assign lane_done = busy_q && !sts[0].busy && !sts[1].busy && !sts[2].busy;

  // per-lane deficit sums and divisors
  always_comb begin
    logic signed [35:0] def [3];
    logic signed [35:0] sum;
    logic [1:0]         cnt;
    for (int i = 0; i < 3; i++) def[i] = 36'(tgt_q[i]) - 36'(vec[i]);
    for (int i = 0; i < 3; i++) begin
      sum = '0;
      cnt = '0;
      for (int j = 0; j < 3; j++) begin
        if (grp_q[j] == grp_q[i]) begin
          sum = sum + def[j];
          cnt = cnt + 2'd1;
        end
      end
      cmd[i].start = in_acc && !is_scale && lane_mode;
      cmd[i].fixed = 1'b0;
      case (mode_q)
        MODE_ISO: begin
          cmd[i].dsum = 36'(tgt_q[0]) * 36'sd3 - 36'(vec[0]) - 36'(vec[1]) - 36'(vec[2]);
          cmd[i].k    = 2'd3;
        end
        MODE_ANI: begin
          cmd[i].dsum = def[i];
          cmd[i].k    = 2'd1;
        end
        default: begin
          cmd[i].dsum  = sum;
          cmd[i].k     = cnt;
          cmd[i].fixed = (grp_q[i] == 2'd0);
        end
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bsf_root_lane #(.FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)) u_root (
      .clk_i, .rst_ni, .cmd_i(cmd[g]), .gain_i(gain_q), .sts_o(sts[g])
    );
    bsf_scale_lane #(.COORD_WIDTH(COORD_WIDTH), .FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)) u_scale (
      .clk_i, .load_i(in_acc && is_scale), .vec_i(vec[g]), .factor_i(fac_q[g]),
      .coord_o(coord[g]), .sat_o(sat[g])
    );
  end

  assign merge_st = stat_max(sts[0].st, stat_max(sts[1].st, sts[2].st));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      gain_q  <= '0;
      busy_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        tgt_q[i] <= '0;
        grp_q[i] <= '0;
        fac_q[i] <= ONE_F;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:    mode_q   <= cfg_wdata_i[2:0];
          CFG_GAIN:    gain_q   <= cfg_wdata_i;
          CFG_TGT_X:   tgt_q[0] <= cfg_wdata_i[31:0];
          CFG_TGT_Y:   tgt_q[1] <= cfg_wdata_i[31:0];
          CFG_TGT_Z:   tgt_q[2] <= cfg_wdata_i[31:0];
          CFG_GROUP_X: grp_q[0] <= cfg_wdata_i[1:0];
          CFG_GROUP_Y: grp_q[1] <= cfg_wdata_i[1:0];
          CFG_GROUP_Z: grp_q[2] <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      s1_v_q <= (in_acc && is_scale) || (s1_v_q && !out_load);
      if (in_acc && !is_scale && lane_mode) busy_q <= 1'b1;
      else if (lane_done) busy_q <= 1'b0;
      if (upd_imm && mode_q != MODE_FULL) begin
        for (int i = 0; i < 3; i++) fac_q[i] <= ONE_F;
      end else if (lane_done) begin
        for (int i = 0; i < 3; i++) fac_q[i] <= sts[i].factor;
      end
      if ((s1_v_q && out_load) || upd_imm || lane_done) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && out_load) begin
      out_q.out_x  <= coord[0];
      out_q.out_y  <= coord[1];
      out_q.out_z  <= coord[2];
      out_q.status <= (sat[0] || sat[1] || sat[2]) ? ST_SATURATED : ST_OK;
    end else if (upd_imm) begin
      if (mode_q == MODE_FULL) begin
        out_q.out_x  <= fac_q[0];
        out_q.out_y  <= fac_q[1];
        out_q.out_z  <= fac_q[2];
        out_q.status <= ST_UNSUPPORTED;
      end else begin
        out_q.out_x  <= ONE_F;
        out_q.out_y  <= ONE_F;
        out_q.out_z  <= ONE_F;
        out_q.status <= ST_OK;
      end
    end else if (lane_done) begin
      out_q.out_x  <= sts[0].factor;
      out_q.out_y  <= sts[1].factor;
      out_q.out_z  <= sts[2].factor;
      out_q.status <= merge_st;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_acc) else $error("word accepted while lanes busy");
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> !out_v_q && !s1_v_q) else $error("lane result with output slot taken");
  a_update_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_scale) |-> !s1_v_q) else $error("update overtook a scale word");
  a_factor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(upd_imm || lane_done) |=> $stable(fac_q[0])) else $error("factor changed unexpectedly");

endmodule
